[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[hdl/q2r_pkg.sv]
// Types and constants for the quaternion to rotation matrix block.
// No dependencies.
`default_nettype none
package q2r_pkg;
  localparam int CW     = 16;          // component width
  localparam int FRAC   = 14;          // output fraction bits
  localparam int OW     = FRAC + 2;    // output width
  localparam int PROD_W = 2 * CW;
  localparam int N_W    = PROD_W + 1;  // sum of four squares
  localparam int NUM_W  = PROD_W + 2;  // signed numerators
  localparam int MAG_W  = N_W;         // |num| <= n
  localparam int D_W    = N_W + 1;     // divisor 2n
  localparam int QB     = FRAC + 1;    // quotient bits
  localparam int REM_W  = MAG_W + QB + 1;
  localparam int LANES  = 9;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC;
  localparam logic signed [OW-1:0] ONE = OW'(1) << FRAC;

  typedef struct packed {
    logic signed [CW-1:0] quat_w;
    logic signed [CW-1:0] quat_x;
    logic signed [CW-1:0] quat_y;
    logic signed [CW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OW-1:0] m00;
    logic signed [OW-1:0] m01;
    logic signed [OW-1:0] m02;
    logic signed [OW-1:0] m10;
    logic signed [OW-1:0] m11;
    logic signed [OW-1:0] m12;
    logic signed [OW-1:0] m20;
    logic signed [OW-1:0] m21;
    logic signed [OW-1:0] m22;
    logic                 zero_input;
  } mat_t;

  // Sideband that rides along the divider stages.
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } div_side_t;
endpackage
`default_nettype wire

[hdl/q2r_divider.sv]
// Restoring divider pipeline, one quotient bit per stage, nine lanes sharing one divisor.
// Depends on q2r_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module q2r_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic [q2r_pkg::REM_W-1:0]     dividend [q2r_pkg::LANES],
  input  wire logic [q2r_pkg::D_W-1:0]       divisor,
  input  wire q2r_pkg::div_side_t            in_side,
  output logic                               out_vld,
  output logic [q2r_pkg::QB-1:0]             quot [q2r_pkg::LANES],
  output q2r_pkg::div_side_t                 out_side
);
  localparam int S  = q2r_pkg::QB;
  localparam int L  = q2r_pkg::LANES;
  localparam int RW = q2r_pkg::REM_W;

  logic [RW-1:0]              rem  [S+1][L];
  logic [q2r_pkg::QB-1:0]     qacc [S+1][L];
  logic [q2r_pkg::D_W-1:0]    dv   [S+1];
  q2r_pkg::div_side_t         side [S+1];
  logic [S:0]                 vld;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      rem[0][l]  = dividend[l];
      qacc[0][l] = '0;
    end
    dv[0]   = divisor;
    side[0] = in_side;
    vld[0]  = in_vld;
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    localparam int SH = S - 1 - s;
    logic [RW-1:0] dsh;
    assign dsh = RW'(dv[s]) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[s+1]   <= dv[s];
        side[s+1] <= side[s];
        for (int l = 0; l < L; l++) begin
          if (rem[s][l] >= dsh) begin
            rem[s+1][l]  <= rem[s][l] - dsh;
            qacc[s+1][l] <= qacc[s][l] | (q2r_pkg::QB'(1) << SH);
          end else begin
            rem[s+1][l]  <= rem[s][l];
            qacc[s+1][l] <= qacc[s][l];
          end
        end
      end
    end
  end

  assign out_vld  = vld[S];
  assign out_side = side[S];
  always_comb begin
    for (int l = 0; l < L; l++) quot[l] = qacc[S][l];
  end

  // lane 0 remainder stays below the divisor once all bits are taken (zero divisor excluded)
  `ASSERT_CLK(a_rem_lt_div, (out_vld && !out_side.zero) |-> (rem[S][0] < q2r_pkg::REM_W'(dv[S])))
  `ASSERT_CLK(a_vld_moves, (en && vld[0]) |=> vld[1])
  `ASSERT_ALWAYS(a_rst_clear, $past(rst) |-> !out_vld)
endmodule
`default_nettype wire

[hdl/quaternion_to_rotation_matrix.sv]
// Top level: quaternion in, 3x3 rotation matrix (Q2.14) out.
// Depends on q2r_pkg, q2r_divider and assert_macros.svh.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------
//   input   | quat_valid, quat_ready | quat (quat_t)
//   output  | mat_valid, mat_ready   | mat  (mat_t)
//
// One word per cycle unless stalled; steps: products, sums, dividend setup,
// 15 divider stages (one quotient bit each), then saturation into the
// output register. The whole pipeline advances together when the output
// register is empty or taken; a stall freezes every stage. Reset clears
// the valid bits only.
`default_nettype none
`include "assert_macros.svh"
module quaternion_to_rotation_matrix (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           quat_valid,
  output logic                quat_ready,
  input  wire q2r_pkg::quat_t quat,
  output logic                mat_valid,
  input  wire logic           mat_ready,
  output q2r_pkg::mat_t       mat
);
  localparam int L = q2r_pkg::LANES;

  logic adv;
  assign adv        = !mat_valid || mat_ready;
  assign quat_ready = adv;

  // stage 1: products
  logic v1;
  logic signed [q2r_pkg::PROD_W-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic z1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= quat_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ww <= quat.quat_w * quat.quat_w;
      xx <= quat.quat_x * quat.quat_x;
      yy <= quat.quat_y * quat.quat_y;
      zz <= quat.quat_z * quat.quat_z;
      xy <= quat.quat_x * quat.quat_y;
      xz <= quat.quat_x * quat.quat_z;
      yz <= quat.quat_y * quat.quat_z;
      wx <= quat.quat_w * quat.quat_x;
      wy <= quat.quat_w * quat.quat_y;
      wz <= quat.quat_w * quat.quat_z;
      z1 <= (quat.quat_w == '0) && (quat.quat_x == '0)
         && (quat.quat_y == '0) && (quat.quat_z == '0);
    end
  end

  // stage 2: norm and numerators
  localparam int NW = q2r_pkg::NUM_W;
  logic v2, z2;
  logic [q2r_pkg::N_W-1:0] n2;
  logic signed [NW-1:0] num [L];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      z2 <= z1;
      n2 <= q2r_pkg::N_W'($unsigned(NW'(ww) + NW'(xx) + NW'(yy) + NW'(zz)));
      num[0] <= NW'(ww) + NW'(xx) - NW'(yy) - NW'(zz);
      num[1] <= (NW'(xy) - NW'(wz)) <<< 1;
      num[2] <= (NW'(xz) + NW'(wy)) <<< 1;
      num[3] <= (NW'(xy) + NW'(wz)) <<< 1;
      num[4] <= NW'(ww) - NW'(xx) + NW'(yy) - NW'(zz);
      num[5] <= (NW'(yz) - NW'(wx)) <<< 1;
      num[6] <= (NW'(xz) - NW'(wy)) <<< 1;
      num[7] <= (NW'(yz) + NW'(wx)) <<< 1;
      num[8] <= NW'(ww) - NW'(xx) - NW'(yy) + NW'(zz);
    end
  end

  // stage 3: dividend = |num| * 2^(F+1) + n, divisor = 2n
  logic v3;
  logic [q2r_pkg::REM_W-1:0] dvd [L];
  logic [q2r_pkg::D_W-1:0]   dvs;
  q2r_pkg::div_side_t        side3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dvs        <= {n2, 1'b0};
      side3.zero <= z2;
      for (int l = 0; l < L; l++) begin
        side3.neg[l] <= num[l][NW-1];
        dvd[l] <= (q2r_pkg::REM_W'(q2r_pkg::MAG_W'(num[l][NW-1] ? -num[l] : num[l]))
                   << q2r_pkg::QB) + q2r_pkg::REM_W'(n2);
      end
    end
  end

  // divider stages
  logic                    vq;
  logic [q2r_pkg::QB-1:0]  quot [L];
  q2r_pkg::div_side_t      sideq;
  q2r_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v3),
    .dividend (dvd),
    .divisor  (dvs),
    .in_side  (side3),
    .out_vld  (vq),
    .quot     (quot),
    .out_side (sideq)
  );

  // final: saturate, restore sign, identity for the zero quaternion
  logic signed [q2r_pkg::OW-1:0] ent [L];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      logic [q2r_pkg::QB-1:0] mg;
      logic signed [q2r_pkg::OW-1:0] sv;
      mg = (quot[l] > q2r_pkg::ONE_Q) ? q2r_pkg::ONE_Q : quot[l];
      sv = $signed(q2r_pkg::OW'(mg));
      if (sideq.zero) ent[l] = (l % 4 == 0) ? q2r_pkg::ONE : '0;
      else ent[l] = sideq.neg[l] ? -sv : sv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) mat_valid <= 1'b0;
    else if (adv) mat_valid <= vq;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mat.m00 <= ent[0]; mat.m01 <= ent[1]; mat.m02 <= ent[2];
      mat.m10 <= ent[3]; mat.m11 <= ent[4]; mat.m12 <= ent[5];
      mat.m20 <= ent[6]; mat.m21 <= ent[7]; mat.m22 <= ent[8];
      mat.zero_input <= sideq.zero;
    end
  end

  `ASSERT_CLK(a_zero_ident, (mat_valid && mat.zero_input) |->
    (mat.m00 == q2r_pkg::ONE && mat.m11 == q2r_pkg::ONE && mat.m01 == '0))
  `ASSERT_CLK(a_diag_range, mat_valid |->
    (mat.m00 <= q2r_pkg::ONE && mat.m00 >= -q2r_pkg::ONE))
  `ASSERT_CLK(a_stall_hold, (mat_valid && !mat_ready) |=> (mat_valid && $stable(mat)))
endmodule
`default_nettype wire

[dv/quaternion_to_rotation_matrix_test.sv]
// Testbench for quaternion_to_rotation_matrix: random and directed quaternions,
// checked word by word against an exact rational predictor. Depends on q2r_pkg.
module quaternion_to_rotation_matrix_test;
  logic clk = 0;
  logic rst = 1;
  logic quat_valid = 0;
  logic quat_ready;
  q2r_pkg::quat_t quat = '0;
  logic mat_valid;
  logic mat_ready = 0;
  q2r_pkg::mat_t mat;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_start = 0;
  int hold_taken = 0;
  int hold_off = 0;
  int mismatches = 0;
  longint cycles = 0;
  q2r_pkg::mat_t expected_mats[$];

  quaternion_to_rotation_matrix dut (.*);

  always #10 clk = ~clk;

  // Round num*2^FRAC/n to nearest, ties away from zero, clamp to +-1.0.
  function automatic logic signed [q2r_pkg::OW-1:0] ratio_q(longint num, longint n);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << (q2r_pkg::FRAC + 1)) + n) / (2 * n);
    if (q > (64'sd1 << q2r_pkg::FRAC)) q = 64'sd1 << q2r_pkg::FRAC;
    return (num < 0) ? q2r_pkg::OW'(-q) : q2r_pkg::OW'(q);
  endfunction

  function automatic q2r_pkg::mat_t rotation_of(q2r_pkg::quat_t qv);
    longint w, x, y, z, n;
    q2r_pkg::mat_t m;
    w = qv.quat_w; x = qv.quat_x; y = qv.quat_y; z = qv.quat_z;
    n = w*w + x*x + y*y + z*z;
    m = '0;
    if (n == 0) begin
      m.m00 = q2r_pkg::ONE; m.m11 = q2r_pkg::ONE; m.m22 = q2r_pkg::ONE; m.zero_input = 1;
      return m;
    end
    m.m00 = ratio_q(w*w + x*x - y*y - z*z, n);
    m.m01 = ratio_q(2*(x*y - w*z), n);
    m.m02 = ratio_q(2*(x*z + w*y), n);
    m.m10 = ratio_q(2*(x*y + w*z), n);
    m.m11 = ratio_q(w*w - x*x + y*y - z*z, n);
    m.m12 = ratio_q(2*(y*z - w*x), n);
    m.m20 = ratio_q(2*(x*z - w*y), n);
    m.m21 = ratio_q(2*(y*z + w*x), n);
    m.m22 = ratio_q(w*w - x*x - y*y + z*z, n);
    return m;
  endfunction

  // Drop valid only for idle cycles; back to back words keep it high.
  task automatic send_quat(logic [15:0] w, x, y, z);
    q2r_pkg::quat_t qv;
    qv = '{w, x, y, z};
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      quat_valid <= 0;
      @(posedge clk);
    end
    quat <= qv;
    quat_valid <= 1;
    @(posedge clk);
    while (!quat_ready) @(posedge clk);
    expected_mats.push_back(rotation_of(qv));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here.
  always @(posedge clk) begin
    if (rst) mat_ready <= 0;
    else if (hold_taken != hold_start) begin
      hold_taken <= hold_start;
      hold_off <= 60;
      mat_ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      mat_ready <= 0;
    end else mat_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && mat_valid && mat_ready) begin
      if (expected_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix word %h", mat);
      end else begin
        q2r_pkg::mat_t e;
        e = expected_mats.pop_front();
        if (e !== mat) begin
          mismatches++;
          if (mismatches <= 10) $display("matrix mismatch: expected %h actual %h", e, mat);
        end
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(3))
      0: return 16'($urandom_range(15)) - 16'd8;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(1, 0, 0, 0);
    send_quat(0, 1, 0, 0);
    send_quat(0, 0, 1, 0);
    send_quat(0, 0, 0, 1);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 0, 0, 0);
    send_quat(0, 16'h8000, 0, 0);
    send_quat(0, 0, 16'h7fff, 16'h8000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'hffff, 16'hffff, 1, 1);
    send_quat(1, 1, 1, 1);
    send_quat(16'hffff, 0, 0, 0);
    send_quat(3, 4, 0, 0);
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start <= hold_start + 1;
    repeat (50) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(150, 0, 0);
    test_random(150, 51, 0);
    test_random(150, 0, 51);
    test_random(150, 25, 25);
    test_backpressure();
    quat_valid <= 0;
    recv_stall_pct = 0;
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
